// ----- rtl/sbusfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sbusfd_pkg
// Shared constants and helpers for the SBUS frame decoder.
// ----------------------------------------------------------------------------
package sbusfd_pkg;

  localparam int DATA_BYTES   = 22;
  localparam int CHANNEL_BITS = 11;
  localparam int FLAG_BITS    = 4;
  localparam int PHASE_BITS   = 5;

  typedef logic [7:0]            byte_t;
  typedef logic [PHASE_BITS-1:0] phase_t;

  localparam byte_t START_BYTE = 8'h0F;
  localparam byte_t END_BYTE_0 = 8'h00;
  localparam byte_t END_BYTE_1 = 8'h04;
  localparam byte_t END_BYTE_2 = 8'h14;
  localparam byte_t END_BYTE_3 = 8'h24;
  localparam byte_t END_BYTE_4 = 8'h34;

  localparam phase_t PHASE_HUNT  = '0;
  localparam phase_t PHASE_FIRST = PHASE_BITS'(1);
  localparam phase_t PHASE_FLAGS = PHASE_BITS'(DATA_BYTES + 1);
  localparam phase_t PHASE_END   = PHASE_BITS'(DATA_BYTES + 2);

  function automatic logic end_byte_ok(input byte_t b);
    return (b == END_BYTE_0) || (b == END_BYTE_1) || (b == END_BYTE_2) ||
           (b == END_BYTE_3) || (b == END_BYTE_4);
  endfunction

endpackage

// ----- rtl/sbus_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// SBUS frame decoder: serial bytes in, 16 channel words out per good frame.
// ----------------------------------------------------------------------------
// Input channel rx_byte/rx_valid/rx_ready takes one UART byte per word. Bytes
// are taken every cycle; rx_ready drops only on an end byte while the frame
// queue (two frames) is full. Bytes before a 0x0F start byte are dropped; a
// frame is start, 22 data bytes, a flags byte and an end byte.
// A frame with a good end byte yields CHANNEL_COUNT output words in channel
// order, last set on the final one; a bad end byte yields nothing.
// The first channel word passes the frame queue, the unpacker's shift register
// and the output register after the end byte is taken. The unpacker emits one
// word per cycle while the receiver is ready, shifting one channel at a time.
// When the receiver stalls, the output register holds its word and the queue
// fills; bytes of the next frame keep flowing until its end byte.
// Reset (rst, synchronous) returns to hunting and empties queue and output.
// ----------------------------------------------------------------------------
module sbus_frame_decoder #(
  parameter int CHANNEL_COUNT = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sbusfd_pkg::byte_t    rx_byte,
  input  logic                 rx_valid,
  output logic                 rx_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           channel_index,
  output logic [sbusfd_pkg::CHANNEL_BITS-1:0] channel_value,
  output logic                 digital_ch17,
  output logic                 digital_ch18,
  output logic                 frame_drop,
  output logic                 failsafe_active,
  output logic                 last
);
  import sbusfd_pkg::*;

  localparam int QueueBits = CHANNEL_COUNT * CHANNEL_BITS + FLAG_BITS;
  localparam logic [3:0] LastChannel = 4'(CHANNEL_COUNT - 1);

  logic                 q_push;
  logic                 q_ready;
  logic [QueueBits-1:0] q_wdata;
  logic [QueueBits-1:0] q_rdata;
  logic                 q_valid;
  logic                 q_pop;

  sbusfd_front #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_byte  (rx_byte),
    .rx_valid (rx_valid),
    .rx_ready (rx_ready),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_ready  (q_ready)
  );

  sbusfd_fifo #(.WIDTH(QueueBits)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_wdata),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_data   (q_rdata),
    .pop_valid  (q_valid)
  );

  sbusfd_back #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_data          (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .channel_index   (channel_index),
    .channel_value   (channel_value),
    .digital_ch17    (digital_ch17),
    .digital_ch18    (digital_ch18),
    .frame_drop      (frame_drop),
    .failsafe_active (failsafe_active),
    .last            (last)
  );

  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (channel_index == LastChannel)))
    else $error("last flag does not match final channel");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> !q_ready)
    else $error("input stalled while frame queue has room");

  a_channels_contiguous: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=>
      (out_valid && (channel_index == $past(channel_index) + 4'd1)))
    else $error("channel words of a frame not back to back");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_ready)
    else $error("frame pushed into full queue");

endmodule

// ----- rtl/sbusfd_front.sv -----
// ----------------------------------------------------------------------------
// sbusfd_front
// Byte hunter and frame assembler; pushes complete, valid frames to the queue.
// ----------------------------------------------------------------------------
module sbusfd_front #(
  parameter int CHANNEL_COUNT = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sbusfd_pkg::byte_t    rx_byte,
  input  logic                 rx_valid,
  output logic                 rx_ready,
  output logic                 q_push,
  output logic [CHANNEL_COUNT*sbusfd_pkg::CHANNEL_BITS+sbusfd_pkg::FLAG_BITS-1:0] q_data,
  input  logic                 q_ready
);
  import sbusfd_pkg::*;

  localparam int FrameBits = CHANNEL_COUNT * CHANNEL_BITS;

  phase_t                    phase;
  phase_t                    phase_next;
  logic [DATA_BYTES*8-1:0]   data_bits;
  logic [FLAG_BITS-1:0]      flags;
  logic                      accept;
  logic                      hunting;
  logic                      at_end;

  // out-of-range phase behaves like hunting
  assign hunting  = (phase == PHASE_HUNT) || (phase > PHASE_END);
  assign at_end   = (phase == PHASE_END);
  // only the end byte can stall, and only when the queue is full
  assign rx_ready = !(at_end && !q_ready);
  assign accept   = rx_valid && rx_ready;

  always_comb begin
    priority if (hunting) begin
      phase_next = (rx_byte == START_BYTE) ? PHASE_FIRST : PHASE_HUNT;
    end else if (at_end) begin
      phase_next = PHASE_HUNT;
    end else begin
      phase_next = phase + PHASE_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PHASE_HUNT;
      flags <= '0;
    end else if (accept) begin
      phase <= phase_next;
      if (phase == PHASE_FLAGS) begin
        flags <= rx_byte[FLAG_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DATA_BYTES; i++) begin
      if (accept && (phase == PHASE_BITS'(i + 1))) begin
        data_bits[i*8 +: 8] <= rx_byte;
      end
    end
  end

  assign q_push = accept && at_end && end_byte_ok(rx_byte);
  assign q_data = {flags, data_bits[FrameBits-1:0]};

endmodule

// ----- rtl/sbusfd_fifo.sv -----
// ----------------------------------------------------------------------------
// sbusfd_fifo
// Two-entry frame queue between the assembler and the channel unpacker.
// ----------------------------------------------------------------------------
module sbusfd_fifo #(
  parameter int WIDTH = 180
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             pop_valid
);
  import sbusfd_pkg::*;

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/sbusfd_back.sv -----
// ----------------------------------------------------------------------------
// sbusfd_back
// Channel unpacker: unless stalled, one 11-bit channel per cycle to the output.
// ----------------------------------------------------------------------------
module sbusfd_back #(
  parameter int CHANNEL_COUNT = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  logic [CHANNEL_COUNT*sbusfd_pkg::CHANNEL_BITS+sbusfd_pkg::FLAG_BITS-1:0] q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           channel_index,
  output logic [sbusfd_pkg::CHANNEL_BITS-1:0] channel_value,
  output logic                 digital_ch17,
  output logic                 digital_ch18,
  output logic                 frame_drop,
  output logic                 failsafe_active,
  output logic                 last
);
  import sbusfd_pkg::*;

  localparam int FrameBits = CHANNEL_COUNT * CHANNEL_BITS;
  localparam logic [3:0] LastChannel = 4'(CHANNEL_COUNT - 1);

  logic                 busy;
  logic [FrameBits-1:0] frame_sh;
  logic [FLAG_BITS-1:0] flags;
  logic [3:0]           ch;
  logic                 step;
  logic                 last_now;

  assign last_now = (ch == LastChannel);
  assign step     = busy && (!out_valid || out_ready);
  assign q_pop    = q_valid && (!busy || (step && last_now));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
      end else if (step && last_now) begin
        busy <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      frame_sh <= q_data[FrameBits-1:0];
      flags    <= q_data[FrameBits +: FLAG_BITS];
      ch       <= '0;
    end else if (step) begin
      frame_sh <= frame_sh >> CHANNEL_BITS;
      ch       <= ch + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      channel_index   <= ch;
      channel_value   <= frame_sh[CHANNEL_BITS-1:0];
      digital_ch17    <= flags[0];
      digital_ch18    <= flags[1];
      frame_drop      <= flags[2];
      failsafe_active <= flags[3];
      last            <= last_now;
    end
  end

endmodule
